### rtl/spoc_pkg.sv
package spoc_pkg;

  typedef logic [7:0] byte_t;

  // parser mode codes
  localparam logic [1:0] MODE_OPCODE = 2'd0;
  localparam logic [1:0] MODE_LENGTH = 2'd1;
  localparam logic [1:0] MODE_DATA   = 2'd2;

  // opcodes of interest
  localparam byte_t OP_PUSH_MAX   = 8'h4b;
  localparam byte_t OP_PUSHDATA1  = 8'h4c;
  localparam byte_t OP_PUSHDATA2  = 8'h4d;
  localparam byte_t OP_PUSH_LEN4  = 8'h4e;
  localparam byte_t OP_NEG_CONST  = 8'h4f;
  localparam byte_t OP_SMALL_LO   = 8'h51;
  localparam byte_t OP_SMALL_HI   = 8'h60;

  typedef struct packed {
    logic [1:0]  parse_mode;
    logic [2:0]  length_bytes_left;
    logic [1:0]  length_shift;
    logic [31:0] length_accum;
    logic [31:0] data_bytes_left;
    logic        failed;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    parse_mode:        MODE_OPCODE,
    length_bytes_left: 3'd0,
    length_shift:      2'd0,
    length_accum:      32'd0,
    data_bytes_left:   32'd0,
    failed:            1'b0
  };

endpackage

### rtl/spoc_if.sv
interface spoc_in_if;
  logic                valid;
  logic                ready;
  spoc_pkg::byte_t     script_byte;
  logic                last_byte;
  logic                empty_script;

  modport source (output valid, output script_byte, output last_byte, output empty_script,
                  input ready);
  modport sink   (input valid, input script_byte, input last_byte, input empty_script,
                  output ready);
endinterface

interface spoc_out_if;
  logic valid;
  logic ready;
  logic push_only;

  modport source (output valid, output push_only, input ready);
  modport sink   (input valid, input push_only, output ready);
endinterface

### rtl/spoc_parser.sv
module spoc_parser (
  input  spoc_pkg::parse_state_t cur,
  input  spoc_pkg::byte_t        script_byte,
  input  logic                   last_byte,
  input  logic                   empty_script,
  output spoc_pkg::parse_state_t nxt,
  output logic                   push_only
);
  import spoc_pkg::*;

  parse_state_t st;
  logic [31:0]  accum_new;
  logic [2:0]   left_new;
  logic [31:0]  data_new;

  assign accum_new = cur.length_accum | (32'(script_byte) << {cur.length_shift, 3'b000});
  assign left_new  = cur.length_bytes_left - 3'd1;
  assign data_new  = cur.data_bytes_left - 32'd1;

  always_comb begin
    st = cur;
    if (!empty_script && !cur.failed) begin
      unique case (cur.parse_mode)
        MODE_OPCODE: begin
          if (script_byte == OP_NEG_CONST ||
              (script_byte >= OP_SMALL_LO && script_byte <= OP_SMALL_HI)) begin
            st = cur;
          end else if (script_byte <= OP_PUSH_MAX) begin
            st.data_bytes_left = 32'(script_byte);
            if (script_byte != 8'd0) st.parse_mode = MODE_DATA;
          end else if (script_byte <= OP_PUSH_LEN4) begin
            st.length_bytes_left = (script_byte == OP_PUSHDATA1) ? 3'd1 :
                                   (script_byte == OP_PUSHDATA2) ? 3'd2 : 3'd4;
            st.length_shift      = 2'd0;
            st.length_accum      = 32'd0;
            st.parse_mode        = MODE_LENGTH;
          end else begin
            st.failed = 1'b1;
          end
        end
        MODE_LENGTH: begin
          st.length_accum      = accum_new;
          st.length_shift      = cur.length_shift + 2'd1;
          st.length_bytes_left = left_new;
          if (left_new == 3'd0) begin
            st.data_bytes_left = accum_new;
            st.parse_mode      = (accum_new != 32'd0) ? MODE_DATA : MODE_OPCODE;
          end
        end
        MODE_DATA: begin
          st.data_bytes_left = data_new;
          if (data_new == 32'd0) st.parse_mode = MODE_OPCODE;
        end
        default: st = cur;
      endcase
    end
  end

  assign push_only = !st.failed && (st.parse_mode == MODE_OPCODE);
  // the script ends here: start clean for the next one
  assign nxt = last_byte ? STATE_RESET : st;

endmodule

### rtl/script_push_only_check_unit.sv
// The last byte is held in the input stage, its result in the result register.
// Throughput: one byte transaction per cycle, sustained; only a last byte waiting
//   on a full, stalled result register holds the input back.
// Reset: synchronous, active low; clears the input stage, the result register
//   and the parse state, so the next byte is taken as the first opcode.
module script_push_only_check_unit (
  input  logic        clk,
  input  logic        rst_n,
  spoc_in_if.sink     in_ch,
  spoc_out_if.source  out_ch
);
  import spoc_pkg::*;

  // input stage
  logic  s1_valid_r;
  byte_t s1_byte_r;
  logic  s1_last_r;
  logic  s1_empty_r;

  // parse state, one script at a time
  parse_state_t state_r;
  parse_state_t state_nxt;
  logic         push_only_nxt;

  // result register
  logic out_valid_r;
  logic out_push_only_r;

  logic out_free;
  logic advance;

  // Result slot is free when empty or being drained this cycle.
  assign out_free = !out_valid_r || out_ch.ready;
  // Non-last bytes make no result and never wait on the output side.
  assign advance  = s1_valid_r && (!s1_last_r || out_free);

  assign in_ch.ready = !s1_valid_r || advance;

  spoc_parser u_parser (
    .cur          (state_r),
    .script_byte  (s1_byte_r),
    .last_byte    (s1_last_r),
    .empty_script (s1_empty_r),
    .nxt          (state_nxt),
    .push_only    (push_only_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  // input payload, loaded on each accepted transaction
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r  <= in_ch.script_byte;
      s1_last_r  <= in_ch.last_byte;
      s1_empty_r <= in_ch.empty_script;
    end
  end

  // parse state moves only when the staged byte is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last_r) begin
      out_push_only_r <= push_only_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.push_only = out_push_only_r;

endmodule

### rtl/spoc_checker.sv
module spoc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic push_only
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(push_only))
    else $error("result dropped or changed while stalled");

  // input only stalls behind a full, stalled result register
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with result side free");

  // reset empties both sides
  a_reset: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("not idle after reset");

endmodule

bind script_push_only_check_unit spoc_checker u_spoc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .push_only (out_ch.push_only)
);
